/* design/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Types, register indexes and margins shared by the PSU supervisor files.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_OVP_TRIP_MV         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCP_TRIP_MA         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVP_CONFIRM_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OCP_CONFIRM_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_CONFIRM_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_SETPOINT_MV = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_SETPOINT_MA = 3'd6;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_OVP  = 2'd1;
   localparam logic [1:0] FAULT_OCP  = 2'd2;

   localparam logic [15:0] CC_CURRENT_MARGIN_MA = 16'd50;
   localparam logic [15:0] CC_VOLTAGE_DROP_MV   = 16'd200;
   localparam logic [15:0] CV_CURRENT_MARGIN_MA = 16'd100;
   localparam logic [15:0] CV_VOLTAGE_MARGIN_MV = 16'd100;

   typedef struct packed {
      logic [15:0] ovp_trip_mv;
      logic [15:0] ocp_trip_ma;
      logic [15:0] ovp_confirm_count;
      logic [15:0] ocp_confirm_count;
      logic [15:0] mode_confirm_count;
      logic [15:0] voltage_setpoint_mv;
      logic [15:0] current_setpoint_ma;
   } cfg_type;

   typedef struct packed {
      logic [15:0] meas_volt_mv;
      logic [15:0] meas_amp_ma;
      logic        precharge_done;
      logic        grace_active;
      logic        regulating;
   } req_type;

   typedef struct packed {
      logic [1:0]  fault_kind;
      logic        fault_active;
      logic        trip_now;
      logic        mode_cc;
      logic [15:0] trip_volt_mv;
      logic [15:0] trip_amp_ma;
      logic [31:0] ovp_transient_total;
      logic [31:0] ocp_transient_total;
   } rsp_type;

endpackage

/* design/psu_if.sv */
// ----------------------------------------------------------------------------
// psu_if
// Valid/ready channels of the PSU supervisor: sample, result and CSR write.
// ----------------------------------------------------------------------------
interface psu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] meas_volt_mv;
   logic [15:0] meas_amp_ma;
   logic        precharge_done;
   logic        grace_active;
   logic        regulating;

   modport source (output valid, meas_volt_mv, meas_amp_ma, precharge_done, grace_active,
                   regulating, input ready);
   modport sink   (input valid, meas_volt_mv, meas_amp_ma, precharge_done, grace_active,
                   regulating, output ready);
endinterface

interface psu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  fault_kind;
   logic        fault_active;
   logic        trip_now;
   logic        mode_cc;
   logic [15:0] trip_volt_mv;
   logic [15:0] trip_amp_ma;
   logic [31:0] ovp_transient_total;
   logic [31:0] ocp_transient_total;

   modport source (output valid, fault_kind, fault_active, trip_now, mode_cc,
                   trip_volt_mv, trip_amp_ma, ovp_transient_total,
                   ocp_transient_total, input ready);
   modport sink   (input valid, fault_kind, fault_active, trip_now, mode_cc,
                   trip_volt_mv, trip_amp_ma, ovp_transient_total,
                   ocp_transient_total, output ready);
endinterface

interface psu_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/psu_csr.sv */
// ----------------------------------------------------------------------------
// psu_csr
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module psu_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [psu_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [15:0]                wr_data,
   output psu_pkg::cfg_type           cfg
);
   import psu_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_OVP_TRIP_MV:         cfg_in.ovp_trip_mv         = wr_data;
            CSR_OCP_TRIP_MA:         cfg_in.ocp_trip_ma         = wr_data;
            CSR_OVP_CONFIRM_COUNT:   cfg_in.ovp_confirm_count   = wr_data;
            CSR_OCP_CONFIRM_COUNT:   cfg_in.ocp_confirm_count   = wr_data;
            CSR_MODE_CONFIRM_COUNT:  cfg_in.mode_confirm_count  = wr_data;
            CSR_VOLTAGE_SETPOINT_MV: cfg_in.voltage_setpoint_mv = wr_data;
            CSR_CURRENT_SETPOINT_MA: cfg_in.current_setpoint_ma = wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ovp_trip_mv         <= 16'hFFFF;
         cfg_ff.ocp_trip_ma         <= 16'hFFFF;
         cfg_ff.ovp_confirm_count   <= 16'd4;
         cfg_ff.ocp_confirm_count   <= 16'd4;
         cfg_ff.mode_confirm_count  <= 16'd8;
         cfg_ff.voltage_setpoint_mv <= 16'd0;
         cfg_ff.current_setpoint_ma <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/psu_core.sv */
// ----------------------------------------------------------------------------
// psu_core
// Sample register, protection and CV/CC mode state, and result register.
// ----------------------------------------------------------------------------
module psu_core (
   input  logic              clock,
   input  logic              reset,
   input  psu_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  psu_pkg::req_type  in_item,
   output logic              in_ready,
   output logic              out_valid,
   output psu_pkg::rsp_type  out_item,
   input  logic              out_ready
);
   import psu_pkg::*;

   logic        advance;
   logic        s1_valid_ff;
   req_type     s1_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] ovp_run_ff, ovp_run_in, ocp_run_ff, ocp_run_in;
   logic [31:0] ovp_tr_ff, ovp_tr_in, ocp_tr_ff, ocp_tr_in;
   logic        latched_ff, latched_in;
   logic [1:0]  code_ff, code_in;
   logic [15:0] tv_ff, tv_in, ta_ff, ta_in;
   logic        cc_ff, cc_in;
   logic [15:0] cc_run_ff, cc_run_in, cv_run_ff, cv_run_in;

   logic        ov, oc, ovc, occ, trip, cand;
   logic [16:0] i_ext, v_ext, is_ext, vs_ext;
   logic [15:0] r_ov, r_oc, r_md;

   assign advance  = !rsp_valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      ov     = s1_ff.meas_volt_mv >= cfg.ovp_trip_mv;
      oc     = s1_ff.meas_amp_ma >= cfg.ocp_trip_ma;
      i_ext  = {1'b0, s1_ff.meas_amp_ma};
      v_ext  = {1'b0, s1_ff.meas_volt_mv};
      is_ext = {1'b0, cfg.current_setpoint_ma};
      vs_ext = {1'b0, cfg.voltage_setpoint_mv};

      ovp_run_in = ovp_run_ff;
      ocp_run_in = ocp_run_ff;
      ovp_tr_in  = ovp_tr_ff;
      ocp_tr_in  = ocp_tr_ff;
      latched_in = latched_ff;
      code_in    = code_ff;
      tv_in      = tv_ff;
      ta_in      = ta_ff;
      cc_in      = cc_ff;
      cc_run_in  = cc_run_ff;
      cv_run_in  = cv_run_ff;
      trip       = 1'b0;
      ovc        = 1'b0;
      occ        = 1'b0;
      cand       = 1'b0;
      r_ov       = 16'd0;
      r_oc       = 16'd0;
      r_md       = 16'd0;

      if (!latched_ff) begin
         if (!s1_ff.precharge_done || s1_ff.grace_active) begin
            ovp_run_in = 16'd0;
            ocp_run_in = 16'd0;
            if (s1_ff.grace_active) begin
               if (ov) ovp_tr_in = ovp_tr_ff + 32'd1;
               if (oc) ocp_tr_in = ocp_tr_ff + 32'd1;
            end
         end else begin
            if (ov) begin
               r_ov = (ovp_run_ff < cfg.ovp_confirm_count) ? ovp_run_ff + 16'd1 : ovp_run_ff;
               if (r_ov < cfg.ovp_confirm_count) ovp_tr_in = ovp_tr_ff + 32'd1;
            end
            if (oc) begin
               r_oc = (ocp_run_ff < cfg.ocp_confirm_count) ? ocp_run_ff + 16'd1 : ocp_run_ff;
               if (r_oc < cfg.ocp_confirm_count) ocp_tr_in = ocp_tr_ff + 32'd1;
            end
            ovp_run_in = r_ov;
            ocp_run_in = r_oc;
            ovc  = r_ov >= cfg.ovp_confirm_count;
            occ  = r_oc >= cfg.ocp_confirm_count;
            trip = ovc || occ;
         end

         if (trip) begin
            latched_in = 1'b1;
            code_in    = ovc ? FAULT_OVP : FAULT_OCP;
            tv_in      = s1_ff.meas_volt_mv;
            ta_in      = s1_ff.meas_amp_ma;
            cc_in      = 1'b0;
            cc_run_in  = 16'd0;
            cv_run_in  = 16'd0;
         end else if (!s1_ff.regulating) begin
            cc_in     = 1'b0;
            cc_run_in = 16'd0;
            cv_run_in = 16'd0;
         end else if (!cc_ff) begin
            cv_run_in = 16'd0;
            cand = (i_ext + {1'b0, CC_CURRENT_MARGIN_MA} >= is_ext) &&
                   (v_ext + {1'b0, CC_VOLTAGE_DROP_MV} < vs_ext);
            if (cand) begin
               r_md = (cc_run_ff < cfg.mode_confirm_count) ? cc_run_ff + 16'd1 : cc_run_ff;
               if (r_md >= cfg.mode_confirm_count) begin
                  cc_in     = 1'b1;
                  cc_run_in = 16'd0;
               end else begin
                  cc_run_in = r_md;
               end
            end else begin
               cc_run_in = 16'd0;
            end
         end else begin
            cc_run_in = 16'd0;
            cand = (i_ext + {1'b0, CV_CURRENT_MARGIN_MA} < is_ext) ||
                   (v_ext + {1'b0, CV_VOLTAGE_MARGIN_MV} >= vs_ext);
            if (cand) begin
               r_md = (cv_run_ff < cfg.mode_confirm_count) ? cv_run_ff + 16'd1 : cv_run_ff;
               if (r_md >= cfg.mode_confirm_count) begin
                  cc_in     = 1'b0;
                  cv_run_in = 16'd0;
               end else begin
                  cv_run_in = r_md;
               end
            end else begin
               cv_run_in = 16'd0;
            end
         end
      end

      rsp_in.fault_kind          = code_in;
      rsp_in.fault_active        = latched_in;
      rsp_in.trip_now            = trip;
      rsp_in.mode_cc             = cc_in;
      rsp_in.trip_volt_mv        = tv_in;
      rsp_in.trip_amp_ma         = ta_in;
      rsp_in.ovp_transient_total = ovp_tr_in;
      rsp_in.ocp_transient_total = ocp_tr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ovp_run_ff   <= 16'd0;
         ocp_run_ff   <= 16'd0;
         ovp_tr_ff    <= 32'd0;
         ocp_tr_ff    <= 32'd0;
         latched_ff   <= 1'b0;
         code_ff      <= FAULT_NONE;
         tv_ff        <= 16'd0;
         ta_ff        <= 16'd0;
         cc_ff        <= 1'b0;
         cc_run_ff    <= 16'd0;
         cv_run_ff    <= 16'd0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            ovp_run_ff <= ovp_run_in;
            ocp_run_ff <= ocp_run_in;
            ovp_tr_ff  <= ovp_tr_in;
            ocp_tr_ff  <= ocp_tr_in;
            latched_ff <= latched_in;
            code_ff    <= code_in;
            tv_ff      <= tv_in;
            ta_ff      <= ta_in;
            cc_ff      <= cc_in;
            cc_run_ff  <= cc_run_in;
            cv_run_ff  <= cv_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (in_valid) s1_ff <= in_item;
         if (s1_valid_ff) rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

endmodule

/* design/psu_protection_and_mode_supervisor.sv */
// ----------------------------------------------------------------------------
// psu_protection_and_mode_supervisor
// OVP/OCP trip confirmation with fault latch, and CV/CC mode tracking.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  req_chan  in   valid/ready    voltage, current, precharge/grace/regulating
//  rsp_chan  out  valid/ready    fault, mode, trip readings, transient totals
//  csr_chan  in   valid/ready    register index, 16-bit data (always ready)
//
//  One item per cycle while the result is not stalled; an item taken passes
//  through the sample register, then the result register, where it is valid.
//  Synchronous reset restores register defaults and clears all state but the sample and result data.
//  A stalled result holds both stages; req_chan.ready drops only then.
// ----------------------------------------------------------------------------
module psu_protection_and_mode_supervisor (
   input  logic      clock,
   input  logic      reset,
   psu_req_if.sink   req_chan,
   psu_rsp_if.source rsp_chan,
   psu_csr_if.sink   csr_chan
);
   import psu_pkg::*;

   cfg_type cfg;
   req_type req_item;
   rsp_type rsp_item;

   assign csr_chan.ready = 1'b1;

   psu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   assign req_item.meas_volt_mv   = req_chan.meas_volt_mv;
   assign req_item.meas_amp_ma    = req_chan.meas_amp_ma;
   assign req_item.precharge_done = req_chan.precharge_done;
   assign req_item.grace_active   = req_chan.grace_active;
   assign req_item.regulating     = req_chan.regulating;

   psu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_chan.valid),
      .in_item   (req_item),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_item  (rsp_item),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.fault_kind          = rsp_item.fault_kind;
   assign rsp_chan.fault_active        = rsp_item.fault_active;
   assign rsp_chan.trip_now            = rsp_item.trip_now;
   assign rsp_chan.mode_cc             = rsp_item.mode_cc;
   assign rsp_chan.trip_volt_mv        = rsp_item.trip_volt_mv;
   assign rsp_chan.trip_amp_ma         = rsp_item.trip_amp_ma;
   assign rsp_chan.ovp_transient_total = rsp_item.ovp_transient_total;
   assign rsp_chan.ocp_transient_total = rsp_item.ocp_transient_total;

endmodule
